[rtl/biquad_iir_filter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Biquad filter assertion macros
// Shared property forms for the checker. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH
`define BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define BQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define BQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check what a reset cycle leaves behind.
`define BQ_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) $past(rst) |-> (cons)) else $error(msg);

`endif

[rtl/bq_pkg.sv]
// ----------------------------------------------------------------------------
// Biquad filter package
// Field widths, register indexes, coefficient bundle and saturating sum.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CMP_W      = SAMPLE_W + 1;

  localparam logic [SAMPLE_W-1:0] COEF_A0_RESET = 32'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A0    = 3'd0,
    CFG_A1    = 3'd1,
    CFG_A2    = 3'd2,
    CFG_B1    = 3'd3,
    CFG_B2    = 3'd4,
    CFG_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] a0;
    logic [SAMPLE_W-1:0] a1;
    logic [SAMPLE_W-1:0] a2;
    logic [SAMPLE_W-1:0] b1;
    logic [SAMPLE_W-1:0] b2;
    logic [LIMIT_W-1:0]  limit;
  } coef_t;

  // Add or subtract, then clamp to the signed range of dw bits (dw <= SAMPLE_W).
  function automatic logic signed [SAMPLE_W-1:0] sat_sum(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic                       sub,
    input int unsigned                dw
  );
    logic signed [SAMPLE_W+1:0] s;
    logic signed [SAMPLE_W+1:0] hi;
    logic signed [SAMPLE_W+1:0] lo;
    s  = sub ? ((SAMPLE_W+2)'(a) - (SAMPLE_W+2)'(b)) : ((SAMPLE_W+2)'(a) + (SAMPLE_W+2)'(b));
    hi = ((SAMPLE_W+2)'(1) <<< (dw - 1)) - (SAMPLE_W+2)'(1);
    lo = -hi - (SAMPLE_W+2)'(1);
    if (s > hi) begin
      sat_sum = hi[SAMPLE_W-1:0];
    end else if (s < lo) begin
      sat_sum = lo[SAMPLE_W-1:0];
    end else begin
      sat_sum = s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

[rtl/bq_if.sv]
// ----------------------------------------------------------------------------
// Biquad filter stream interfaces
// Valid/ready channels for input and output sample words.
// ----------------------------------------------------------------------------
interface bq_in_if import bq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bq_out_if import bq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/bq_coef_regs.sv]
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// Write-only register file for gains and the underflow limit.
// ----------------------------------------------------------------------------
module bq_coef_regs import bq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output coef_t                 coef
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.a0    <= COEF_A0_RESET;
      coef.a1    <= '0;
      coef.a2    <= '0;
      coef.b1    <= '0;
      coef.b2    <= '0;
      coef.limit <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A0:    coef.a0    <= cfg_data[SAMPLE_W-1:0];
        CFG_A1:    coef.a1    <= cfg_data[SAMPLE_W-1:0];
        CFG_A2:    coef.a2    <= cfg_data[SAMPLE_W-1:0];
        CFG_B1:    coef.b1    <= cfg_data[SAMPLE_W-1:0];
        CFG_B2:    coef.b2    <= cfg_data[SAMPLE_W-1:0];
        CFG_LIMIT: coef.limit <= cfg_data[LIMIT_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

endmodule

[rtl/bq_mulq.sv]
// ----------------------------------------------------------------------------
// Biquad fixed-point multiplier
// Full signed product, floor shift by the fraction bits, wrap to data width.
// ----------------------------------------------------------------------------
module bq_mulq #(
  parameter int DW = 32,
  parameter int FB = 15
) (
  input  logic signed [DW-1:0] gain,
  input  logic signed [DW-1:0] value,
  output logic signed [DW-1:0] prod
);

  localparam int PW = 2 * DW;
  localparam int EW = PW + FB;

  logic signed [PW-1:0] full;
  logic signed [EW-1:0] ext;
  logic signed [EW-1:0] shifted;

  always_comb begin
    full    = gain * value;
    ext     = EW'(full);
    shifted = ext >>> FB;
    prod    = shifted[DW-1:0];
  end

endmodule

[rtl/bq_feedforward.sv]
// ----------------------------------------------------------------------------
// Biquad feedforward stage
// Input delay line and the saturated sum of the three feedforward taps.
// ----------------------------------------------------------------------------
module bq_feedforward import bq_pkg::*; #(
  parameter int DW = 32,
  parameter int FB = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic signed [DW-1:0] x,
  input  logic signed [DW-1:0] a0,
  input  logic signed [DW-1:0] a1,
  input  logic signed [DW-1:0] a2,
  input  logic                 take,
  output logic                 ff_valid,
  output logic signed [DW-1:0] ff_sum
);

  logic signed [DW-1:0] x1;
  logic signed [DW-1:0] x2;
  logic signed [DW-1:0] p0;
  logic signed [DW-1:0] p1;
  logic signed [DW-1:0] p2;
  logic signed [SAMPLE_W-1:0] s01;
  logic signed [SAMPLE_W-1:0] s012;
  logic signed [DW-1:0] ff_sum_next;

  bq_mulq #(.DW(DW), .FB(FB)) u_mul0 (.gain(a0), .value(x),  .prod(p0));
  bq_mulq #(.DW(DW), .FB(FB)) u_mul1 (.gain(a1), .value(x1), .prod(p1));
  bq_mulq #(.DW(DW), .FB(FB)) u_mul2 (.gain(a2), .value(x2), .prod(p2));

  always_comb begin
    s01         = sat_sum(SAMPLE_W'(p0), SAMPLE_W'(p1), 1'b0, DW);
    s012        = sat_sum(s01, SAMPLE_W'(p2), 1'b0, DW);
    ff_sum_next = s012[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1       <= '0;
      x2       <= '0;
      ff_valid <= 1'b0;
    end else begin
      if (accept) begin
        x1       <= x;
        x2       <= x1;
        ff_valid <= 1'b1;
      end else if (take) begin
        ff_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ff_sum <= ff_sum_next;
    end
  end

endmodule

[rtl/bq_feedback.sv]
// ----------------------------------------------------------------------------
// Biquad feedback stage
// Subtract the two feedback taps, flush underflow, hold the result word.
// ----------------------------------------------------------------------------
module bq_feedback import bq_pkg::*; #(
  parameter int DW = 32,
  parameter int FB = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ff_valid,
  input  logic signed [DW-1:0] ff_sum,
  input  logic signed [DW-1:0] b1,
  input  logic signed [DW-1:0] b2,
  input  logic [LIMIT_W-1:0]   limit,
  input  logic                 out_ready,
  output logic                 take,
  output logic                 out_valid,
  output logic signed [DW-1:0] y
);

  // y1 doubles as the output word register
  logic signed [DW-1:0] y1;
  logic signed [DW-1:0] y2;
  logic signed [DW-1:0] p1;
  logic signed [DW-1:0] p2;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [SAMPLE_W-1:0] s2;
  logic signed [DW-1:0] pre;
  logic signed [DW:0]   pre_ext;
  logic [DW:0]          mag;
  logic                 tiny;
  logic signed [DW-1:0] y_next;

  bq_mulq #(.DW(DW), .FB(FB)) u_mul1 (.gain(b1), .value(y1), .prod(p1));
  bq_mulq #(.DW(DW), .FB(FB)) u_mul2 (.gain(b2), .value(y2), .prod(p2));

  always_comb begin
    s1      = sat_sum(SAMPLE_W'(ff_sum), SAMPLE_W'(p1), 1'b1, DW);
    s2      = sat_sum(s1, SAMPLE_W'(p2), 1'b1, DW);
    pre     = s2[DW-1:0];
    pre_ext = (DW+1)'(pre);
    mag     = pre[DW-1] ? unsigned'(-pre_ext) : unsigned'(pre_ext);
    tiny    = (pre != '0) && (CMP_W'(mag) < CMP_W'(limit));
    y_next  = tiny ? '0 : pre;
  end

  assign take = ff_valid && (!out_valid || out_ready);
  assign y    = y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      y1        <= '0;
      y2        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        y1        <= y_next;
        y2        <= y1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/biquad_iir_filter_unit.sv]
// A word accepted at the input is registered in stage one, then in the output register y1 when stage two takes it.
// Throughput: one word per cycle while the output is taken; the feedback taps close through one registered stage.
// Per cycle the path is one multiplier and two saturating subtracts in the feedback stage.
// Reset (rst, synchronous): empty both stages, clear the sample and output delay lines,
// and load coef_a0 = 1.0 (32768), all other coefficient registers zero.
// ----------------------------------------------------------------------------
// Biquad IIR filter unit
// Direct form I biquad, Q-format samples, saturating sums, underflow flush.
// ----------------------------------------------------------------------------
module biquad_iir_filter_unit import bq_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  bq_in_if.sink                 din,
  bq_out_if.source              dout,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  coef_t                        coef;
  logic                         accept;
  logic                         take;
  logic                         ff_valid;
  logic signed [DATA_WIDTH-1:0] ff_sum;
  logic signed [DATA_WIDTH-1:0] x;
  logic signed [DATA_WIDTH-1:0] y;

  // The user must change coefficients only while the pipe is empty; the block does not enforce this. No shadowing here.
  bq_coef_regs u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Use only the low DATA_WIDTH bits of the incoming word.
  assign x = din.sample_in[DATA_WIDTH-1:0];

  // Stage one takes a new word whenever it is empty or its word moves on
  // this cycle; a full output register alone does not stall the input.
  assign din.ready = !ff_valid || take;
  assign accept    = din.valid && din.ready;

  // Stage one: feedforward taps a0*x + a1*x1 + a2*x2, registered.
  bq_feedforward #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_ff (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .x        (x),
    .a0       (coef.a0[DATA_WIDTH-1:0]),
    .a1       (coef.a1[DATA_WIDTH-1:0]),
    .a2       (coef.a2[DATA_WIDTH-1:0]),
    .take     (take),
    .ff_valid (ff_valid),
    .ff_sum   (ff_sum)
  );

  // Stage two: subtract b1*y1 and b2*y2 against the outputs it just
  // produced, flush tiny results, and hold the word until taken.
  bq_feedback #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_fb (
    .clk       (clk),
    .rst       (rst),
    .ff_valid  (ff_valid),
    .ff_sum    (ff_sum),
    .b1        (coef.b1[DATA_WIDTH-1:0]),
    .b2        (coef.b2[DATA_WIDTH-1:0]),
    .limit     (coef.limit),
    .out_ready (dout.ready),
    .take      (take),
    .out_valid (dout.valid),
    .y         (y)
  );

  // Sign-extend the result to the full word.
  assign dout.sample_out = SAMPLE_W'(y);

endmodule

[rtl/bq_checker.sv]
// ----------------------------------------------------------------------------
// Biquad filter port checker
// Watch the stream ports for reset, latency and backpressure behavior.
// ----------------------------------------------------------------------------
`include "biquad_iir_filter_unit_defines.svh"

module bq_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // reset leaves no output word pending
  `BQ_ASSERT_RST(a_reset_empty, !out_valid, "output valid after reset")

  // a fresh output word traces back to an accepted input word through stage one and the output register
  `BQ_ASSERT_NOW(a_rise_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "output word without matching input")

  // input stalls only when the output side holds back
  `BQ_ASSERT_NOW(a_stall_cause, in_valid && !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

  // a pending output word stays until taken
  `BQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped while stalled")

endmodule

bind biquad_iir_filter_unit bq_checker u_bq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready)
);
